@@ src/i2c_eeprom_byte_access_master_macros.svh @@
// Assertion macros for the I2C EEPROM byte access master.
`ifndef I2C_EEPROM_BYTE_ACCESS_MASTER_MACROS_SVH
`define I2C_EEPROM_BYTE_ACCESS_MASTER_MACROS_SVH

`ifndef SYNTH
// Same-cycle implication, disabled during reset.
`define I2CEE_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("i2cee assertion failed");
// Next-cycle implication, disabled during reset.
`define I2CEE_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("i2cee assertion failed");
`else
`define I2CEE_ASSERT_IMP(label, clk, rst, ante, cons)
`define I2CEE_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

@@ src/i2cee_pkg.sv @@
// Shared types and constants for the I2C EEPROM byte access master.
`default_nettype none

package i2cee_pkg;

  localparam int ADDR_BITS_DEFAULT = 11;
  localparam int FULL_ADDR_BITS = 11;

  localparam logic [1:0] OP_TICK = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [1:0] CFG_TICKS_PER_PHASE = 2'd0;
  localparam logic [1:0] CFG_WRITE_SETTLE = 2'd1;
  localparam logic [1:0] CFG_RETRY_GAP = 2'd2;
  localparam logic [1:0] CFG_MAX_ATTEMPTS = 2'd3;

  localparam logic [15:0] TICKS_PER_PHASE_RESET = 16'd125;
  localparam logic [23:0] WRITE_SETTLE_RESET = 24'd750000;
  localparam logic [23:0] RETRY_GAP_RESET = 24'd50000;
  localparam logic [3:0] MAX_ATTEMPTS_RESET = 4'd9;

  localparam logic [7:0] DEV_WRITE = 8'hA0;
  localparam logic [7:0] DEV_READ = 8'hA1;
  localparam logic [7:0] IDLE_BYTE = 8'hFF;

  typedef struct packed {
    logic [15:0] ticks_per_phase;
    logic [23:0] write_settle_ticks;
    logic [23:0] retry_gap_ticks;
    logic [3:0]  max_read_attempts;
  } cfg_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
  } res_t;

endpackage

`default_nettype wire

@@ src/i2cee_if.sv @@
// Valid/ready channel interfaces for the tick input and the bus result.
`default_nettype none

interface i2cee_in_if #(
  parameter int ADDR_BITS = i2cee_pkg::ADDR_BITS_DEFAULT
);
  logic                 valid;
  logic                 ready;
  logic [1:0]           op;
  logic [ADDR_BITS-1:0] mem_address;
  logic [7:0]           write_data;
  logic                 sda_in;

  modport source (output valid, op, mem_address, write_data, sda_in, input ready);
  modport sink (input valid, op, mem_address, write_data, sda_in, output ready);
endinterface

interface i2cee_out_if;
  logic       valid;
  logic       ready;
  logic       scl_release;
  logic       sda_release;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;

  modport source (output valid, scl_release, sda_release, busy_res, done_res, read_data,
                  input ready);
  modport sink (input valid, scl_release, sda_release, busy_res, done_res, read_data,
                output ready);
endinterface

`default_nettype wire

@@ src/i2c_eeprom_byte_access_master.sv @@
// Top level of the tick-driven I2C EEPROM byte access master.
//
// Each beat on in_ch is one tick of the bus sequencer. It carries a request
// code, an EEPROM byte address, write data and the sampled SDA level. A write
// or read request is taken only while the sequencer is idle or done; on any
// other tick the request code is ignored. For every input beat one beat is
// sent on out_ch with the SCL and SDA release levels, busy, a one-tick done
// pulse and the byte of the last finished read.
// An input beat is handled combinationally; its result beat is valid in the
// output register on the next cycle, and one beat per cycle is sustained while out_ch is ready.
// If the receiver stalls, the output register holds its beat and in_ch.ready
// falls until it is taken; the sequencer does not advance without a beat.
// Configuration registers are written through cfg_we, cfg_index and cfg_data
// and take effect on the next tick.
// Reset returns the sequencer to idle with the bus released, clears the
// output register and loads the configuration defaults.
`default_nettype none

`include "i2c_eeprom_byte_access_master_macros.svh"

module i2c_eeprom_byte_access_master #(
  parameter int ADDR_BITS = i2cee_pkg::ADDR_BITS_DEFAULT
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_we,
  input wire logic [1:0]  cfg_index,
  input wire logic [23:0] cfg_data,
  i2cee_in_if.sink        in_ch,
  i2cee_out_if.source     out_ch
);

  i2cee_pkg::cfg_t cfg;
  i2cee_pkg::res_t res;
  i2cee_pkg::res_t out_beat;
  logic            out_valid;
  logic            accept;
  logic            out_free;
  logic            bus_released;

  assign in_ch.ready = !out_valid || out_ch.ready;
  assign accept = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.ticks_per_phase <= i2cee_pkg::TICKS_PER_PHASE_RESET;
      cfg.write_settle_ticks <= i2cee_pkg::WRITE_SETTLE_RESET;
      cfg.retry_gap_ticks <= i2cee_pkg::RETRY_GAP_RESET;
      cfg.max_read_attempts <= i2cee_pkg::MAX_ATTEMPTS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        i2cee_pkg::CFG_TICKS_PER_PHASE: cfg.ticks_per_phase <= cfg_data[15:0];
        i2cee_pkg::CFG_WRITE_SETTLE: cfg.write_settle_ticks <= cfg_data;
        i2cee_pkg::CFG_RETRY_GAP: cfg.retry_gap_ticks <= cfg_data;
        i2cee_pkg::CFG_MAX_ATTEMPTS: cfg.max_read_attempts <= cfg_data[3:0];
        default: cfg <= cfg;
      endcase
    end
  end

  i2cee_core #(
    .ADDR_BITS(ADDR_BITS)
  ) u_core (
    .clk(clk),
    .rst(rst),
    .step(accept),
    .op(in_ch.op),
    .mem_address(in_ch.mem_address),
    .write_data(in_ch.write_data),
    .sda_in(in_ch.sda_in),
    .cfg(cfg),
    .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_beat <= '0;
    end else if (accept) begin
      out_beat <= res;
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.scl_release = out_beat.scl_release;
  assign out_ch.sda_release = out_beat.sda_release;
  assign out_ch.busy_res = out_beat.busy_res;
  assign out_ch.done_res = out_beat.done_res;
  assign out_ch.read_data = out_beat.read_data;

  assign out_free = out_valid && !out_beat.busy_res;
  assign bus_released = out_beat.scl_release && out_beat.sda_release;

  `I2CEE_ASSERT_NXT(a_accept_fills_output, clk, rst, accept, out_ch.valid)
  `I2CEE_ASSERT_IMP(a_busy_done_exclusive, clk, rst, out_valid, !(out_beat.busy_res && out_beat.done_res))
  `I2CEE_ASSERT_IMP(a_bus_released_when_free, clk, rst, out_free, bus_released)

endmodule

`default_nettype wire

@@ src/i2cee_core.sv @@
// Bus sequencer state, stepped on each accepted tick, and its combinational next-state logic.
`default_nettype none

module i2cee_core #(
  parameter int ADDR_BITS = i2cee_pkg::ADDR_BITS_DEFAULT
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire logic [1:0]           op,
  input  wire logic [ADDR_BITS-1:0] mem_address,
  input  wire logic [7:0]           write_data,
  input  wire logic                 sda_in,
  input  wire i2cee_pkg::cfg_t      cfg,
  output i2cee_pkg::res_t           res
);

  localparam int FA = i2cee_pkg::FULL_ADDR_BITS;

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_S0 = 5'd1;
  localparam logic [4:0] ST_S1 = 5'd2;
  localparam logic [4:0] ST_S2 = 5'd3;
  localparam logic [4:0] ST_S3 = 5'd4;
  localparam logic [4:0] ST_B0 = 5'd5;
  localparam logic [4:0] ST_B1 = 5'd6;
  localparam logic [4:0] ST_B2 = 5'd7;
  localparam logic [4:0] ST_B3 = 5'd8;
  localparam logic [4:0] ST_P0 = 5'd9;
  localparam logic [4:0] ST_P1 = 5'd10;
  localparam logic [4:0] ST_P2 = 5'd11;
  localparam logic [4:0] ST_SETTLE = 5'd12;
  localparam logic [4:0] ST_GAP = 5'd13;
  localparam logic [4:0] ST_DONE = 5'd14;

  localparam logic [3:0] LAST_DATA_BIT = 4'd8;

  logic [4:0]           sequence_step, sequence_step_next;
  logic [15:0]          phase_timer, phase_timer_next;
  logic [3:0]           bit_counter, bit_counter_next;
  logic [7:0]           shift_byte, shift_byte_next;
  logic [2:0]           byte_counter, byte_counter_next;
  logic [3:0]           attempt_counter, attempt_counter_next;
  logic [7:0]           previous_value, previous_value_next;
  logic [7:0]           first_value, first_value_next;
  logic [23:0]          wait_counter, wait_counter_next;
  logic [ADDR_BITS-1:0] held_address, held_address_next;
  logic [7:0]           held_data, held_data_next;
  logic                 held_is_read, held_is_read_next;
  logic [7:0]           result_byte, result_byte_next;

  logic [FA-1:0] addr_ext;
  logic [15:0]   tpp;
  logic [16:0]   phase_inc;
  logic          phase_end;
  logic [23:0]   wait_len;
  logic [24:0]   wait_inc;
  logic          wait_end;
  logic [3:0]    bit_inc;
  logic [2:0]    byte_inc;
  logic [3:0]    attempt_inc;
  logic [3:0]    limit;

  function automatic logic [7:0] pick_byte(input logic [2:0] bc, input logic [2:0] dev_hi,
                                           input logic [7:0] addr_lo, input logic [7:0] data,
                                           input logic is_read);
    logic [7:0] b;
    b = i2cee_pkg::IDLE_BYTE;
    if (bc == 3'd0) begin
      b = i2cee_pkg::DEV_WRITE | {4'd0, dev_hi, 1'b0};
    end else if (bc == 3'd1) begin
      b = addr_lo;
    end else if (bc == 3'd2) begin
      b = is_read ? (i2cee_pkg::DEV_READ | {4'd0, dev_hi, 1'b0}) : data;
    end
    return b;
  endfunction

  assign addr_ext = FA'(held_address);
  assign tpp = (cfg.ticks_per_phase == 16'd0) ? 16'd1 : cfg.ticks_per_phase;
  assign phase_inc = {1'b0, phase_timer} + 17'd1;
  assign phase_end = phase_inc >= {1'b0, tpp};
  assign wait_len = (sequence_step == ST_SETTLE) ? cfg.write_settle_ticks : cfg.retry_gap_ticks;
  assign wait_inc = {1'b0, wait_counter} + 25'd1;
  assign wait_end = wait_inc >= {1'b0, wait_len};
  assign bit_inc = bit_counter + 4'd1;
  assign byte_inc = byte_counter + 3'd1;
  assign attempt_inc = attempt_counter + 4'd1;
  assign limit = (cfg.max_read_attempts == 4'd0) ? 4'd1 : cfg.max_read_attempts;

  always_comb begin
    sequence_step_next = sequence_step;
    phase_timer_next = phase_timer;
    bit_counter_next = bit_counter;
    shift_byte_next = shift_byte;
    byte_counter_next = byte_counter;
    attempt_counter_next = attempt_counter;
    previous_value_next = previous_value;
    first_value_next = first_value;
    wait_counter_next = wait_counter;
    held_address_next = held_address;
    held_data_next = held_data;
    held_is_read_next = held_is_read;
    result_byte_next = result_byte;

    if (sequence_step >= ST_S0 && sequence_step <= ST_P2) begin
      if (phase_end) begin
        phase_timer_next = 16'd0;
        unique case (sequence_step)
          ST_S3: begin
            shift_byte_next = pick_byte(byte_counter, addr_ext[FA-1:8], addr_ext[7:0],
                                        held_data, held_is_read);
            bit_counter_next = 4'd0;
            sequence_step_next = ST_B0;
          end
          ST_B2: begin
            if (bit_counter < LAST_DATA_BIT) begin
              shift_byte_next = {shift_byte[6:0], sda_in};
            end
            sequence_step_next = ST_B3;
          end
          ST_B3: begin
            bit_counter_next = bit_inc;
            if (bit_inc <= LAST_DATA_BIT) begin
              sequence_step_next = ST_B0;
            end else begin
              byte_counter_next = byte_inc;
              if ((!held_is_read && byte_inc < 3'd3) || (held_is_read && byte_inc == 3'd3)) begin
                shift_byte_next = pick_byte(byte_inc, addr_ext[FA-1:8], addr_ext[7:0],
                                            held_data, held_is_read);
                bit_counter_next = 4'd0;
                sequence_step_next = ST_B0;
              end else if (held_is_read && byte_inc == 3'd2) begin
                sequence_step_next = ST_S0;
              end else begin
                sequence_step_next = ST_P0;
              end
            end
          end
          ST_P2: begin
            wait_counter_next = 24'd0;
            if (!held_is_read) begin
              sequence_step_next = (cfg.write_settle_ticks == 24'd0) ? ST_DONE : ST_SETTLE;
            end else if (attempt_counter != 4'd0 && previous_value == shift_byte) begin
              result_byte_next = shift_byte;
              sequence_step_next = ST_DONE;
            end else begin
              if (attempt_counter == 4'd0) begin
                first_value_next = shift_byte;
              end
              previous_value_next = shift_byte;
              attempt_counter_next = attempt_inc;
              if (attempt_inc >= limit) begin
                result_byte_next = first_value_next;
                sequence_step_next = ST_DONE;
              end else if (cfg.retry_gap_ticks == 24'd0) begin
                byte_counter_next = 3'd0;
                sequence_step_next = ST_S0;
              end else begin
                sequence_step_next = ST_GAP;
              end
            end
          end
          default: begin
            sequence_step_next = sequence_step + 5'd1;
          end
        endcase
      end else begin
        phase_timer_next = phase_inc[15:0];
      end
    end else if (sequence_step == ST_SETTLE || sequence_step == ST_GAP) begin
      if (wait_end) begin
        wait_counter_next = 24'd0;
        if (sequence_step == ST_SETTLE) begin
          sequence_step_next = ST_DONE;
        end else begin
          byte_counter_next = 3'd0;
          phase_timer_next = 16'd0;
          sequence_step_next = ST_S0;
        end
      end else begin
        wait_counter_next = wait_inc[23:0];
      end
    end else begin
      sequence_step_next = ST_IDLE;
      if (op == i2cee_pkg::OP_WRITE || op == i2cee_pkg::OP_READ) begin
        held_address_next = mem_address;
        held_data_next = write_data;
        held_is_read_next = (op == i2cee_pkg::OP_READ);
        attempt_counter_next = 4'd0;
        wait_counter_next = 24'd0;
        byte_counter_next = 3'd0;
        phase_timer_next = 16'd0;
        sequence_step_next = ST_S0;
      end
    end
  end

  always_comb begin
    res.scl_release = 1'b1;
    res.sda_release = 1'b1;
    unique case (sequence_step_next)
      ST_S0: res.scl_release = 1'b0;
      ST_S2: res.sda_release = 1'b0;
      ST_S3, ST_P0: begin
        res.scl_release = 1'b0;
        res.sda_release = 1'b0;
      end
      ST_B0, ST_B1, ST_B2, ST_B3: begin
        res.scl_release = (sequence_step_next == ST_B1 || sequence_step_next == ST_B2);
        res.sda_release = (bit_counter_next >= LAST_DATA_BIT) ? 1'b1 : shift_byte_next[7];
      end
      ST_P1: res.sda_release = 1'b0;
      default: begin
        res.scl_release = 1'b1;
        res.sda_release = 1'b1;
      end
    endcase
    res.busy_res = (sequence_step_next >= ST_S0 && sequence_step_next <= ST_GAP);
    res.done_res = (sequence_step_next == ST_DONE);
    res.read_data = result_byte_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sequence_step <= ST_IDLE;
      phase_timer <= '0;
      bit_counter <= '0;
      shift_byte <= '0;
      byte_counter <= '0;
      attempt_counter <= '0;
      previous_value <= '0;
      first_value <= '0;
      wait_counter <= '0;
      held_address <= '0;
      held_data <= '0;
      held_is_read <= 1'b0;
      result_byte <= '0;
    end else if (step) begin
      sequence_step <= sequence_step_next;
      phase_timer <= phase_timer_next;
      bit_counter <= bit_counter_next;
      shift_byte <= shift_byte_next;
      byte_counter <= byte_counter_next;
      attempt_counter <= attempt_counter_next;
      previous_value <= previous_value_next;
      first_value <= first_value_next;
      wait_counter <= wait_counter_next;
      held_address <= held_address_next;
      held_data <= held_data_next;
      held_is_read <= held_is_read_next;
      result_byte <= result_byte_next;
    end
  end

endmodule

`default_nettype wire
